[rtl/core/hmbp_pkg.sv]
// Package for the HTTP message byte parser: payload types, state codes and
// character class helpers. No dependencies.
package hmbp_pkg;

  localparam int LEN_BITS = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0] parse_status;
    logic [7:0] out_byte;
    logic [2:0] byte_kind;
    logic       entry_done;
    logic [7:0] major_version;
    logic [7:0] minor_version;
    logic [9:0] status_code;
    logic [1:0] phase;
    logic       body_chunked;
  } out_item_t;

  typedef enum logic [5:0] {
    S_METHOD_START, S_METHOD, S_URI,
    S_RQ_H, S_RQ_T1, S_RQ_T2, S_RQ_P, S_RQ_SLASH,
    S_RQ_MAJ0, S_RQ_MAJ, S_RQ_MIN0, S_RQ_MIN, S_RQ_LF,
    S_RS_H, S_RS_T1, S_RS_T2, S_RS_P, S_RS_SLASH,
    S_RS_MAJ0, S_RS_MAJ, S_RS_MIN0, S_RS_MIN,
    S_RS_CODE0, S_RS_CODE, S_RS_TEXT0, S_RS_TEXT, S_RS_LF,
    S_HL_START, S_HL_LWS, S_H_NAME, S_H_SPACE, S_H_VALUE, S_H_LF, S_END_LF,
    S_CK_LEN0, S_CK_LEN, S_CK_LF, S_CK_DATA, S_CK_DATA_LF, S_CK_TRAIL,
    S_CK_END_LF, S_FIXED
  } pstate_t;

  localparam logic [1:0] HK_OTHER = 2'd0;
  localparam logic [1:0] HK_TE    = 2'd1;
  localparam logic [1:0] HK_CL    = 2'd2;

  localparam logic [1:0] FIN_RUN  = 2'd0;
  localparam logic [1:0] FIN_DONE = 2'd1;
  localparam logic [1:0] FIN_BAD  = 2'd2;

  localparam logic [2:0] BK_NONE   = 3'd0;
  localparam logic [2:0] BK_METHOD = 3'd1;
  localparam logic [2:0] BK_URI    = 3'd2;
  localparam logic [2:0] BK_TEXT   = 3'd3;
  localparam logic [2:0] BK_HNAME  = 3'd4;
  localparam logic [2:0] BK_HVALUE = 3'd5;
  localparam logic [2:0] BK_BODY   = 3'd6;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  function automatic logic is_ctl(input logic [7:0] b);
    return (b < 8'd32) || (b == 8'd127);
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    logic sep;
    sep = (b == "(") || (b == ")") || (b == "<") || (b == "@") || (b == ",") ||
          (b == ";") || (b == ":") || (b == "\\") || (b == "\"") || (b == "/") ||
          (b == "[") || (b == "]") || (b == "?") || (b == "=") || (b == "{") ||
          (b == "}") || (b == " ") || (b == 8'h09);
    return !b[7] && !is_ctl(b) && !sep;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;
  endfunction

  function automatic logic [7:0] http_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "n";
      5'd4: c = "s"; 5'd5: c = "f"; 5'd6: c = "e"; 5'd7: c = "r";
      5'd8: c = "-"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "c";
      5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
      5'd16: c = "g";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cl_char(input logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0: c = "c"; 5'd1: c = "o"; 5'd2: c = "n"; 5'd3: c = "t";
      5'd4: c = "e"; 5'd5: c = "n"; 5'd6: c = "t"; 5'd7: c = "-";
      5'd8: c = "l"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "g";
      5'd12: c = "t"; 5'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] chunked_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "u"; 3'd3: c = "n";
      3'd4: c = "k"; 3'd5: c = "e"; 3'd6: c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/hmbp_out_buf.sv]
// Two-entry output buffer (skid) for result items of the HTTP parser.
// Depends on hmbp_pkg for the result item type.
module hmbp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hmbp_pkg::out_item_t push_item,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output hmbp_pkg::out_item_t out_item
);
  import hmbp_pkg::*;

  out_item_t main_r, skid_r;
  logic      main_v_r, skid_v_r;

  assign out_valid = main_v_r;
  assign out_item  = main_r;
  assign can_push  = !skid_v_r;

  // Advance main from skid or the new item; park in skid while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r || out_ready) begin
        if (skid_v_r) begin
          main_r   <= skid_r;
          main_v_r <= 1'b1;
          skid_v_r <= 1'b0;
          if (push) begin
            skid_r   <= push_item;
            skid_v_r <= 1'b1;
          end
        end else begin
          main_v_r <= push;
          if (push) main_r <= push_item;
        end
      end else if (push) begin
        skid_r   <= push_item;
        skid_v_r <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push) else $error("push into full buffer");
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r) else $error("skid holds item without main");
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !out_ready) |=> main_v_r) else $error("stalled item lost");
`endif
endmodule

[rtl/core/http_message_byte_parser_top.sv]
// Top level of the HTTP/1.x message byte parser: parse state machine and
// result buffer. Depends on hmbp_pkg and hmbp_out_buf.
//
// channel | ports                         | payload
// input   | in_valid, in_ready, in_item   | data_byte, restart
// result  | out_valid, out_ready, out_item| status, tagged byte, fields
// config  | cfg_we, cfg_wdata             | message_kind
//
// One byte per cycle: a byte is parsed in the cycle it is accepted and its
// result is registered into a two-entry buffer.
// in_ready falls only while both buffer entries are full.
// Reset (synchronous rst_n) selects request parsing at method start.
// The 32-bit length counter update is the longest path (multiply by ten).
module http_message_byte_parser_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hmbp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hmbp_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import hmbp_pkg::*;

  logic                kind_r;
  pstate_t             st_r, st_nxt;
  logic [LEN_BITS-1:0] rem_r, rem_nxt;
  logic [7:0]          maj_r, maj_nxt, min_r, min_nxt;
  logic [9:0]          stat_r, stat_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                seen_r, seen_nxt;
  logic [4:0]          nidx_r, nidx_nxt;
  logic [1:0]          ncand_r, ncand_nxt;
  logic [1:0]          hk_r, hk_nxt;
  logic [2:0]          tidx_r, tidx_nxt;
  logic [1:0]          tph_r, tph_nxt;
  logic                chk_r, chk_nxt;
  logic                lseen_r, lseen_nxt;
  logic [LEN_BITS-1:0] lval_r, lval_nxt;
  logic [1:0]          lph_r, lph_nxt;
  logic [1:0]          fin_r, fin_nxt;

  logic      accept, can_push;
  out_item_t res;

  assign in_ready = can_push;
  assign accept   = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) kind_r <= 1'b0;
    else if (cfg_we) kind_r <= cfg_wdata;
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_METHOD_START; rem_r <= '0; maj_r <= '0; min_r <= '0;
      stat_r <= '0; phase_r <= '0; seen_r <= 1'b0; nidx_r <= '0;
      ncand_r <= 2'b11; hk_r <= HK_OTHER; tidx_r <= '0; tph_r <= '0;
      chk_r <= 1'b0; lseen_r <= 1'b0; lval_r <= '0; lph_r <= '0;
      fin_r <= FIN_RUN;
    end else if (accept) begin
      st_r <= st_nxt; rem_r <= rem_nxt; maj_r <= maj_nxt; min_r <= min_nxt;
      stat_r <= stat_nxt; phase_r <= phase_nxt; seen_r <= seen_nxt;
      nidx_r <= nidx_nxt; ncand_r <= ncand_nxt; hk_r <= hk_nxt;
      tidx_r <= tidx_nxt; tph_r <= tph_nxt; chk_r <= chk_nxt;
      lseen_r <= lseen_nxt; lval_r <= lval_nxt; lph_r <= lph_nxt;
      fin_r <= fin_nxt;
    end
  end

  // Next state and result for one byte
  always_comb begin
    logic [7:0]  b;
    logic [2:0]  bk;
    logic        done, fail;
    pstate_t     go;
    logic        go_en;
    logic [3:0]  d;
    logic [4:0]  hv;
    logic        hex_ok;
    logic [11:0] sat;
    logic [13:0] scode;
    logic [3:0]  tmp4;
    logic        tend;
    logic [LEN_BITS+3:0] lprod;

    b = in_item.data_byte;
    bk = BK_NONE; done = 1'b0; fail = 1'b0; go = st_r; go_en = 1'b0;
    tmp4 = b[3:0];
    d = tmp4;
    hex_ok = 1'b1;
    if (is_dec_digit(b)) hv = {1'b0, b[3:0]};
    else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
      hv = {1'b0, b[3:0]} + 5'd9;
    else begin
      hv = '0; hex_ok = 1'b0;
    end
    sat = 12'd0; scode = 14'd0; tend = 1'b0;
    // Length times ten plus digit; any bit above the length width is overflow
    lprod = {4'd0, lval_r} * (LEN_BITS+4)'(10) + (LEN_BITS+4)'(d);

    st_nxt = st_r; rem_nxt = rem_r; maj_nxt = maj_r; min_nxt = min_r;
    stat_nxt = stat_r; phase_nxt = phase_r; seen_nxt = seen_r;
    nidx_nxt = nidx_r; ncand_nxt = ncand_r; hk_nxt = hk_r; tidx_nxt = tidx_r;
    tph_nxt = tph_r; chk_nxt = chk_r; lseen_nxt = lseen_r; lval_nxt = lval_r;
    lph_nxt = lph_r; fin_nxt = fin_r;

    if (in_item.restart) begin
      st_nxt = kind_r ? S_RS_H : S_METHOD_START;
      rem_nxt = '0; maj_nxt = '0; min_nxt = '0; stat_nxt = '0; phase_nxt = '0;
      seen_nxt = 1'b0; nidx_nxt = '0; ncand_nxt = 2'b11; hk_nxt = HK_OTHER;
      tidx_nxt = '0; tph_nxt = '0; chk_nxt = 1'b0; lseen_nxt = 1'b0;
      lval_nxt = '0; lph_nxt = '0; fin_nxt = FIN_RUN;
    end else if (fin_r == FIN_RUN) begin
      case (st_r)
        S_METHOD_START: begin
          if (is_token(b)) begin bk = BK_METHOD; go = S_METHOD; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_METHOD: begin
          if (b == " ") begin go = S_URI; go_en = 1'b1; end
          else if (is_token(b)) bk = BK_METHOD;
          else fail = 1'b1;
        end
        S_URI: begin
          if (b == " ") begin go = S_RQ_H; go_en = 1'b1; end
          else if (is_ctl(b)) fail = 1'b1;
          else bk = BK_URI;
        end
        S_RQ_H, S_RQ_T1, S_RQ_T2, S_RQ_P, S_RQ_SLASH: begin
          if (b == http_char(3'(st_r - S_RQ_H))) begin
            go = pstate_t'(st_r + 6'd1); go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_RS_H, S_RS_T1, S_RS_T2, S_RS_P, S_RS_SLASH: begin
          if (b == http_char(3'(st_r - S_RS_H))) begin
            go = pstate_t'(st_r + 6'd1); go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_RQ_MAJ0, S_RS_MAJ0: begin
          if (is_dec_digit(b)) begin
            maj_nxt = {4'd0, d}; go = pstate_t'(st_r + 6'd1); go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_RQ_MAJ, S_RS_MAJ: begin
          if (b == ".") begin go = pstate_t'(st_r + 6'd1); go_en = 1'b1; end
          else if (is_dec_digit(b)) begin
            sat = {4'd0, maj_r} * 12'd10 + {8'd0, d};
            maj_nxt = (sat > 12'd255) ? 8'd255 : sat[7:0];
          end else fail = 1'b1;
        end
        S_RQ_MIN0, S_RS_MIN0: begin
          if (is_dec_digit(b)) begin
            min_nxt = {4'd0, d}; go = pstate_t'(st_r + 6'd1); go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_RQ_MIN, S_RS_MIN: begin
          if ((st_r == S_RQ_MIN && b == CH_CR) || (st_r == S_RS_MIN && b == " ")) begin
            go = (st_r == S_RQ_MIN) ? S_RQ_LF : S_RS_CODE0; go_en = 1'b1;
          end else if (is_dec_digit(b)) begin
            sat = {4'd0, min_r} * 12'd10 + {8'd0, d};
            min_nxt = (sat > 12'd255) ? 8'd255 : sat[7:0];
          end else fail = 1'b1;
        end
        S_RS_CODE0: begin
          if (is_dec_digit(b)) begin
            stat_nxt = {6'd0, d}; go = S_RS_CODE; go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_RS_CODE: begin
          if (b == " ") begin go = S_RS_TEXT0; go_en = 1'b1; end
          else if (is_dec_digit(b)) begin
            scode = {4'd0, stat_r} * 14'd10 + {10'd0, d};
            stat_nxt = (scode > 14'd999) ? 10'd999 : scode[9:0];
          end else fail = 1'b1;
        end
        S_RS_TEXT0, S_RS_TEXT: begin
          if (b == CH_CR) begin done = 1'b1; go = S_RS_LF; go_en = 1'b1; end
          else if (!b[7]) begin bk = BK_TEXT; go = S_RS_TEXT; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_RQ_LF, S_RS_LF, S_H_LF: begin
          if (b == CH_LF) begin go = S_HL_START; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_HL_START: begin
          if (b == CH_CR) begin go = S_END_LF; go_en = 1'b1; end
          else if (seen_r && (b == " " || b == 8'h09)) begin
            go = S_HL_LWS; go_en = 1'b1;
          end else if (is_token(b)) begin
            ncand_nxt = {lower(b) == cl_char(5'd0), lower(b) == te_char(5'd0)};
            nidx_nxt = 5'd1;
            bk = BK_HNAME; go = S_H_NAME; go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_HL_LWS: begin
          if (b == CH_CR) begin go = S_H_LF; go_en = 1'b1; end
          else if (b == " " || b == 8'h09) begin end
          else if (is_ctl(b)) fail = 1'b1;
          else begin hk_nxt = HK_OTHER; bk = BK_HVALUE; go = S_H_VALUE; go_en = 1'b1; end
        end
        S_H_NAME: begin
          if (b == ":") begin
            hk_nxt = HK_OTHER;
            if (ncand_r[0] && nidx_r == 5'd17) begin
              hk_nxt = HK_TE; tidx_nxt = '0; tph_nxt = '0;
            end else if (ncand_r[1] && nidx_r == 5'd14 && !lseen_r) begin
              hk_nxt = HK_CL; lseen_nxt = 1'b1; lval_nxt = '0; lph_nxt = '0;
            end
            go = S_H_SPACE; go_en = 1'b1;
          end else if (is_token(b)) begin
            ncand_nxt[0] = ncand_r[0] && (nidx_r < 5'd17) && (lower(b) == te_char(nidx_r));
            ncand_nxt[1] = ncand_r[1] && (nidx_r < 5'd14) && (lower(b) == cl_char(nidx_r));
            if (nidx_r < 5'd31) nidx_nxt = nidx_r + 5'd1;
            bk = BK_HNAME;
          end else fail = 1'b1;
        end
        S_H_SPACE: begin
          if (b == " ") begin go = S_H_VALUE; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_H_VALUE: begin
          if (b == CH_CR) begin
            if (hk_r == HK_TE) tend = 1'b1;
            done = 1'b1; seen_nxt = 1'b1; go = S_H_LF; go_en = 1'b1;
          end else if (is_ctl(b)) fail = 1'b1;
          else begin
            bk = BK_HVALUE;
            if (hk_r == HK_TE) begin
              if (b == ",") tend = 1'b1;
              else begin
                case (tph_r)
                  2'd0: begin
                    if (b != " ") begin
                      if (b == chunked_char(3'd0)) begin tph_nxt = 2'd1; tidx_nxt = 3'd1; end
                      else tph_nxt = 2'd3;
                    end
                  end
                  2'd1: begin
                    if (tidx_r < 3'd7 && b == chunked_char(tidx_r)) tidx_nxt = tidx_r + 3'd1;
                    else if (b == " " && tidx_r == 3'd7) tph_nxt = 2'd2;
                    else tph_nxt = 2'd3;
                  end
                  2'd2: if (b != " ") tph_nxt = 2'd3;
                  default: begin end
                endcase
              end
            end else if (hk_r == HK_CL) begin
              if (is_dec_digit(b)) begin
                if (lph_r[1]) lph_nxt = 2'd3;
                else if (lprod[LEN_BITS+3 -: 4] != 4'd0) lph_nxt = 2'd3;
                else begin
                  lval_nxt = lprod[LEN_BITS-1:0];
                  lph_nxt = 2'd1;
                end
              end else if (b == " ") begin
                if (lph_r == 2'd1) lph_nxt = 2'd2;
              end else lph_nxt = 2'd3;
            end
          end
        end
        S_END_LF: begin
          if (b != CH_LF) fail = 1'b1;
          else if (chk_r) begin go = S_CK_LEN0; go_en = 1'b1; end
          else if (lseen_r) begin
            if (lph_r != 2'd1 && lph_r != 2'd2) fail = 1'b1;
            else if (lval_r == '0) fin_nxt = FIN_DONE;
            else begin rem_nxt = lval_r; go = S_FIXED; go_en = 1'b1; end
          end else fin_nxt = FIN_DONE;
        end
        S_CK_LEN0: begin
          if (hex_ok) begin rem_nxt = LEN_BITS'(hv); go = S_CK_LEN; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_CK_LEN: begin
          if (b == CH_CR) begin go = S_CK_LF; go_en = 1'b1; end
          else if (hex_ok) begin
            if (rem_r[LEN_BITS-1 -: 4] != 4'd0) fail = 1'b1;
            else rem_nxt = {rem_r[LEN_BITS-5:0], hv[3:0]};
          end else fail = 1'b1;
        end
        S_CK_LF: begin
          if (b == CH_LF) begin
            go = (rem_r != '0) ? S_CK_DATA : S_CK_TRAIL; go_en = 1'b1;
          end else fail = 1'b1;
        end
        S_CK_DATA: begin
          if (rem_r == '0) begin
            if (b == CH_CR) begin go = S_CK_DATA_LF; go_en = 1'b1; end
            else fail = 1'b1;
          end else begin bk = BK_BODY; rem_nxt = rem_r - LEN_BITS'(1); end
        end
        S_CK_DATA_LF: begin
          if (b == CH_LF) begin go = S_CK_LEN0; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_CK_TRAIL: begin
          if (b == CH_CR) begin go = S_CK_END_LF; go_en = 1'b1; end
          else fail = 1'b1;
        end
        S_CK_END_LF: begin
          if (b == CH_LF) fin_nxt = FIN_DONE;
          else fail = 1'b1;
        end
        S_FIXED: begin
          bk = BK_BODY;
          if (rem_r > LEN_BITS'(1)) rem_nxt = rem_r - LEN_BITS'(1);
          else begin rem_nxt = '0; fin_nxt = FIN_DONE; end
        end
        default: fail = 1'b1;
      endcase

      // Close a Transfer-Encoding token
      if (tend) begin
        if ((tph_r == 2'd1 && tidx_r == 3'd7) || tph_r == 2'd2) chk_nxt = 1'b1;
        tph_nxt = '0; tidx_nxt = '0;
      end

      // Advance state and phase
      if (go_en) begin
        st_nxt = go;
        if (go == S_HL_START && phase_r == 2'd0) phase_nxt = 2'd1;
        if ((go == S_CK_LEN0 || go == S_FIXED) && phase_r == 2'd1) phase_nxt = 2'd2;
      end
      if (fail) fin_nxt = FIN_BAD;
    end

    res.parse_status  = fin_nxt;
    res.out_byte      = (bk != BK_NONE) ? b : 8'd0;
    res.byte_kind     = bk;
    res.entry_done    = done;
    res.major_version = maj_nxt;
    res.minor_version = min_nxt;
    res.status_code   = stat_nxt;
    res.phase         = phase_nxt;
    res.body_chunked  = chk_nxt;
  end

  hmbp_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_item(res),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

`ifndef NO_ASSERTIONS
  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fin_r != FIN_RUN && !in_item.restart) |=> $stable(fin_r))
    else $error("finished parser left its final status");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.restart) |=> (fin_r == FIN_RUN && phase_r == 2'd0))
    else $error("restart did not clear parser");
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("phase code out of range");
`endif
endmodule
